// ===== src/ppcx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcx_pkg
// Shared operation codes and queue word layout for the integer execute unit.
// ----------------------------------------------------------------------------
package ppcx_pkg;

	typedef enum logic [5:0] {
		OP_ILLEGAL, OP_MULLI, OP_SUBFIC, OP_CMPLI, OP_CMPI, OP_ADDIC, OP_ADDICD,
		OP_ADDI, OP_ADDIS, OP_CRXOR, OP_CREQV, OP_RLWIMI, OP_RLWINM, OP_ORI,
		OP_ORIS, OP_XORI, OP_XORIS, OP_ANDI, OP_ANDIS, OP_CMP, OP_CMPL, OP_MFCR,
		OP_MTCRF, OP_SLW, OP_SRW, OP_SRAW, OP_SRAWI, OP_AND, OP_ANDC, OP_NOR,
		OP_OR, OP_ORC, OP_XOR, OP_CNTLZW, OP_ADD, OP_ADDC, OP_ADDE, OP_SUBF,
		OP_SUBFC, OP_SUBFE, OP_ADDZE, OP_NEG, OP_MULLW, OP_DIVWU, OP_MULHWU,
		OP_MULHW
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] ins;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] s;
	} qword_t;

	function automatic op_t decode(input logic [31:0] ins);
		op_t o;
		logic [9:0] x10;
		logic [8:0] xo;
		logic oe;
		x10 = ins[10:1];
		xo = ins[9:1];
		oe = ins[10];
		o = OP_ILLEGAL;
		unique case (ins[31:26])
			6'd7: o = OP_MULLI;
			6'd8: o = OP_SUBFIC;
			6'd10: o = OP_CMPLI;
			6'd11: o = OP_CMPI;
			6'd12: o = OP_ADDIC;
			6'd13: o = OP_ADDICD;
			6'd14: o = OP_ADDI;
			6'd15: o = OP_ADDIS;
			6'd19: begin
				if (x10 == 10'd193) o = OP_CRXOR;
				else if (x10 == 10'd289) o = OP_CREQV;
			end
			6'd20: o = OP_RLWIMI;
			6'd21: o = OP_RLWINM;
			6'd24: o = OP_ORI;
			6'd25: o = OP_ORIS;
			6'd26: o = OP_XORI;
			6'd27: o = OP_XORIS;
			6'd28: o = OP_ANDI;
			6'd29: o = OP_ANDIS;
			6'd31: begin
				unique case (x10)
					10'd0: o = OP_CMP;
					10'd32: o = OP_CMPL;
					10'd19: o = OP_MFCR;
					10'd144: o = OP_MTCRF;
					10'd24: o = OP_SLW;
					10'd536: o = OP_SRW;
					10'd792: o = OP_SRAW;
					10'd824: o = OP_SRAWI;
					10'd28: o = OP_AND;
					10'd60: o = OP_ANDC;
					10'd124: o = OP_NOR;
					10'd444: o = OP_OR;
					10'd412: o = OP_ORC;
					10'd316: o = OP_XOR;
					10'd26: o = OP_CNTLZW;
					default: begin
						unique case (xo)
							9'd266: o = OP_ADD;
							9'd10: o = OP_ADDC;
							9'd138: o = OP_ADDE;
							9'd40: o = OP_SUBF;
							9'd8: o = OP_SUBFC;
							9'd136: o = OP_SUBFE;
							9'd202: o = OP_ADDZE;
							9'd104: o = OP_NEG;
							9'd235: o = OP_MULLW;
							9'd459: o = OP_DIVWU;
							9'd11: o = oe ? OP_ILLEGAL : OP_MULHWU;
							9'd75: o = oe ? OP_ILLEGAL : OP_MULHW;
							default: o = OP_ILLEGAL;
						endcase
					end
				endcase
			end
			default: o = OP_ILLEGAL;
		endcase
		return o;
	endfunction

endpackage

// ===== src/ppc_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_integer_execute_unit
// 32-bit PowerPC fixed-point execute unit with CR and XER state.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): an instruction word with its rA, rB and rS
// values. Output channel (valid/ready): result, destination, write flag,
// condition register, XER CA/OV/SO and the illegal flag, one word per input.
// The front end decodes the word and parks it in a two-entry queue; the back
// end executes it and loads an output register.
// ALU, logical, shift, compare and CR words are registered in the queue, then
// in the output register, one word per cycle while the receiver takes them;
// multiplies add one registered 33x33 multiplier stage, and divwu holds the
// back end until the one-bit-per-cycle divider is done. Reset clears CR, CA,
// OV, SO and both valid sides. When the receiver stalls the output register
// holds, then the queue fills and ready drops.
// ----------------------------------------------------------------------------
module ppc_integer_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction,
	input  logic [31:0] reg_a_value,
	input  logic [31:0] reg_b_value,
	input  logic [31:0] reg_s_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [4:0]  dest_index,
	output logic        write_enable,
	output logic [31:0] cr_out,
	output logic        carry_out,
	output logic        overflow_out,
	output logic        summary_overflow_out,
	output logic        illegal
);
	import ppcx_pkg::*;

	logic   q_valid, q_ready;
	qword_t q_word;

	ppcx_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.instruction(instruction), .reg_a_value(reg_a_value),
		.reg_b_value(reg_b_value), .reg_s_value(reg_s_value),
		.q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
	);

	ppcx_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_word(q_word), .out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .dest_index(dest_index),
		.write_enable(write_enable), .cr_out(cr_out), .carry_out(carry_out),
		.overflow_out(overflow_out), .summary_overflow_out(summary_overflow_out),
		.illegal(illegal)
	);

endmodule

// ===== src/ppcx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcx_front
// Accepts instruction words, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module ppcx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 ready,
	input  logic [31:0]          instruction,
	input  logic [31:0]          reg_a_value,
	input  logic [31:0]          reg_b_value,
	input  logic [31:0]          reg_s_value,
	output logic                 q_valid,
	input  logic                 q_ready,
	output ppcx_pkg::qword_t     q_word
);
	import ppcx_pkg::*;

	qword_t     mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign push = valid && ready;
	assign pop = q_valid && q_ready;
	assign q_word = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{op: decode(instruction), ins: instruction,
				a: reg_a_value, b: reg_b_value, s: reg_s_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop of empty queue");

endmodule

// ===== src/ppcx_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcx_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppcx_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] q_q, r_q, d_q;
	logic [5:0]  n_q;
	logic [32:0] trial;

	assign busy = n_q != 6'd0;
	assign quotient = q_q;
	assign trial = {r_q, q_q[31]} - {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) r_q <= trial[31:0];
			else r_q <= {r_q[30:0], q_q[31]};
			q_q <= {q_q[30:0], ~trial[32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) n_q <= '0;
		else if (start) n_q <= 6'd32;
		else if (busy) n_q <= n_q - 6'd1;
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy) else $error("divider restarted while busy");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> n_q == 6'd32) else $error("divider count not loaded");
	a_dec: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !start |=> n_q == $past(n_q) - 6'd1) else $error("divider count slip");

endmodule

// ===== src/ppcx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcx_back
// Executes queued words, holds CR and XER state and drives the result port.
// ----------------------------------------------------------------------------
module ppcx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  ppcx_pkg::qword_t  q_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       result_value,
	output logic [4:0]        dest_index,
	output logic              write_enable,
	output logic [31:0]       cr_out,
	output logic              carry_out,
	output logic              overflow_out,
	output logic              summary_overflow_out,
	output logic              illegal
);
	import ppcx_pkg::*;

	typedef enum logic [2:0] {
		ST_EXEC = 3'b001,
		ST_MUL  = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t      state_q;
	logic [31:0] cr_q;
	logic        ca_q, ov_q, so_q;
	logic [63:0] prod_q;
	logic        div_start, div_busy;
	logic [31:0] div_quo;
	logic        slot_free, fin;
	logic [31:0] res;
	logic [4:0]  dst;
	logic        we, ill;
	logic [31:0] cr_n;
	logic        ca_n, ov_n, so_n;

	ppcx_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(q_word.a), .divisor(q_word.b),
		.busy(div_busy), .quotient(div_quo)
	);

	assign slot_free = !out_valid || out_ready;

	function automatic logic [31:0] put_field(input logic [31:0] cr,
			input logic [2:0] fld, input logic [3:0] code);
		logic [31:0] m;
		logic [4:0] sh;
		sh = 5'(28 - 4 * fld);
		m = 32'hf << sh;
		return (cr & ~m) | ({28'd0, code} << sh);
	endfunction

	function automatic logic [3:0] cmp_code(input logic lt, input logic gt,
			input logic so);
		return {lt, !lt && gt, !lt && !gt, so};
	endfunction

	function automatic logic [31:0] rmask(input logic [4:0] mb, input logic [4:0] me);
		logic [31:0] m1, m2;
		m1 = 32'hffffffff >> mb;
		m2 = 32'hffffffff << (5'd31 - me);
		return (mb <= me) ? (m1 & m2) : (m1 | m2);
	endfunction

	// multiply runs in ST_MUL in the cycle after capture of operands
	logic [31:0] ma, mb;
	logic        msign;
	always_comb begin
		ma = q_word.a;
		mb = q_word.b;
		msign = 1'b1;
		case (q_word.op)
			OP_MULLI: mb = {{16{q_word.ins[15]}}, q_word.ins[15:0]};
			OP_MULHWU: msign = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (msign) prod_q <= $signed({ma[31] & msign, ma}) * $signed({mb[31] & msign, mb});
		else prod_q <= {32'd0, ma} * {32'd0, mb};
	end

	always_comb begin
		logic [31:0] a, b, s, simm, uimm, m, r, hi, lo, x, y;
		logic [32:0] t;
		logic [4:0]  rd, ra, rbf;
		logic        oe, rc, cin, c, v, setca, lrc, bit_v;
		logic [5:0]  sa;
		logic [31:0] cm;
		a = q_word.a; b = q_word.b; s = q_word.s;
		rd = q_word.ins[25:21]; ra = q_word.ins[20:16]; rbf = q_word.ins[15:11];
		oe = q_word.ins[10]; rc = q_word.ins[0];
		uimm = {16'd0, q_word.ins[15:0]};
		simm = {{16{q_word.ins[15]}}, q_word.ins[15:0]};
		res = '0; dst = '0; we = 1'b0; ill = 1'b0;
		cr_n = cr_q; ca_n = ca_q; ov_n = ov_q; so_n = so_q;
		x = a; y = b; cin = 1'b0; setca = 1'b0; lrc = 1'b0;
		hi = prod_q[63:32]; lo = prod_q[31:0]; m = '0; r = '0;
		sa = '0; cm = '0; bit_v = 1'b0; c = 1'b0; v = 1'b0;
		unique case (q_word.op)
			OP_SUBFIC: begin x = ~a; y = simm; cin = 1'b1; end
			OP_ADDIC, OP_ADDICD: y = simm;
			OP_ADDC, OP_ADD: ;
			OP_ADDE: cin = ca_q;
			OP_SUBF, OP_SUBFC: begin x = ~a; cin = 1'b1; end
			OP_SUBFE: begin x = ~a; cin = ca_q; end
			OP_ADDZE: begin y = '0; cin = ca_q; end
			OP_NEG: begin x = ~a; y = '0; cin = 1'b1; end
			default: ;
		endcase
		t = {1'b0, x} + {1'b0, y} + {32'd0, cin};
		c = t[32];
		v = (t[31] ^ x[31]) & (t[31] ^ y[31]);
		case (q_word.op)
			OP_ILLEGAL: ill = 1'b1;
			OP_MULLI: begin res = lo; dst = rd; we = 1'b1; end
			OP_SUBFIC, OP_ADDIC: begin res = t[31:0]; ca_n = c; dst = rd; we = 1'b1; end
			OP_ADDICD: begin
				res = t[31:0]; ca_n = c; dst = rd; we = 1'b1; lrc = 1'b1;
			end
			OP_CMPLI: cr_n = put_field(cr_q, rd[4:2], cmp_code(a < uimm, a > uimm, so_q));
			OP_CMPI: cr_n = put_field(cr_q, rd[4:2],
				cmp_code($signed(a) < $signed(simm), $signed(a) > $signed(simm), so_q));
			OP_CMP: cr_n = put_field(cr_q, rd[4:2],
				cmp_code($signed(a) < $signed(b), $signed(a) > $signed(b), so_q));
			OP_CMPL: cr_n = put_field(cr_q, rd[4:2], cmp_code(a < b, a > b, so_q));
			OP_ADDI: begin res = (ra != 0 ? a : 32'd0) + simm; dst = rd; we = 1'b1; end
			OP_ADDIS: begin
				res = (ra != 0 ? a : 32'd0) + {q_word.ins[15:0], 16'd0}; dst = rd; we = 1'b1;
			end
			OP_CRXOR, OP_CREQV: begin
				bit_v = cr_q[5'd31 - ra] ^ cr_q[5'd31 - rbf];
				if (q_word.op == OP_CREQV) bit_v = ~bit_v;
				cr_n[5'd31 - rd] = bit_v;
			end
			OP_RLWIMI, OP_RLWINM: begin
				m = rmask(q_word.ins[10:6], q_word.ins[5:1]);
				r = ((s << rbf) | (s >> (6'd32 - {1'b0, rbf}))) & m;
				res = (q_word.op == OP_RLWIMI) ? (r | (a & ~m)) : r;
				dst = ra; we = 1'b1; lrc = rc;
			end
			OP_ORI: begin res = s | uimm; dst = ra; we = 1'b1; end
			OP_ORIS: begin res = s | (uimm << 16); dst = ra; we = 1'b1; end
			OP_XORI: begin res = s ^ uimm; dst = ra; we = 1'b1; end
			OP_XORIS: begin res = s ^ (uimm << 16); dst = ra; we = 1'b1; end
			OP_ANDI: begin res = s & uimm; dst = ra; we = 1'b1; lrc = 1'b1; end
			OP_ANDIS: begin res = s & (uimm << 16); dst = ra; we = 1'b1; lrc = 1'b1; end
			OP_MFCR: begin res = cr_q; dst = rd; we = 1'b1; end
			OP_MTCRF: begin
				for (int i = 0; i < 8; i++) cm[i*4 +: 4] = {4{q_word.ins[12 + i]}};
				cr_n = (s & cm) | (cr_q & ~cm);
			end
			OP_SLW, OP_SRW, OP_SRAW, OP_SRAWI, OP_AND, OP_ANDC, OP_NOR, OP_OR,
			OP_ORC, OP_XOR, OP_CNTLZW: begin
				dst = ra; we = 1'b1; lrc = rc;
				sa = (q_word.op == OP_SRAWI) ? {1'b0, rbf} : b[5:0];
				case (q_word.op)
					OP_SLW: res = b[5] ? 32'd0 : (s << b[4:0]);
					OP_SRW: res = b[5] ? 32'd0 : (s >> b[4:0]);
					OP_SRAW, OP_SRAWI: begin
						if (sa[5]) begin
							res = {32{s[31]}}; ca_n = s[31];
						end else begin
							res = 32'($signed(s) >>> sa[4:0]);
							ca_n = s[31] && ((s & ~(32'hffffffff << sa[4:0])) != 0);
						end
					end
					OP_AND: res = s & b;
					OP_ANDC: res = s & ~b;
					OP_NOR: res = ~(s | b);
					OP_OR: res = s | b;
					OP_ORC: res = s | ~b;
					OP_XOR: res = s ^ b;
					default: begin
						res = 32'd32;
						for (int i = 0; i < 32; i++) if (s[i]) res = 32'(31 - i);
					end
				endcase
			end
			default: begin
				dst = rd; we = 1'b1;
				case (q_word.op)
					OP_ADD, OP_SUBF, OP_NEG: res = t[31:0];
					OP_ADDC, OP_ADDE, OP_SUBFC, OP_SUBFE, OP_ADDZE: begin
						res = t[31:0]; setca = 1'b1;
					end
					OP_MULLW: begin res = lo; v = hi != {32{lo[31]}}; end
					OP_MULHWU, OP_MULHW: res = hi;
					default: begin
						v = b == 0;
						we = b != 0;
						res = div_quo;
					end
				endcase
				if (setca) ca_n = c;
				if (oe) begin ov_n = v; so_n = so_q | v; end
				if (rc) begin
					if (we) lrc = 1'b1;
					else cr_n[28] = so_n;
				end
			end
		endcase
		if (!we) res = '0;
		if (lrc) cr_n = put_field(cr_n, 3'd0,
			cmp_code(res[31], !res[31] && res != 0, so_n));
	end

	// multiplies wait in ST_MUL for the registered product; divides run the divider
	logic is_mul, is_div;
	assign is_mul = q_word.op == OP_MULLI || q_word.op == OP_MULLW ||
		q_word.op == OP_MULHW || q_word.op == OP_MULHWU;
	assign is_div = q_word.op == OP_DIVWU;
	assign div_start = q_valid && state_q == ST_EXEC && is_div;
	assign fin = q_valid && slot_free && ((state_q == ST_EXEC && !is_mul && !is_div) ||
		state_q == ST_MUL || (state_q == ST_DIV && !div_busy));
	assign q_ready = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXEC;
			cr_q <= '0; ca_q <= 1'b0; ov_q <= 1'b0; so_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_EXEC: begin
					if (q_valid && is_mul) state_q <= ST_MUL;
					else if (q_valid && is_div) state_q <= ST_DIV;
				end
				ST_MUL: if (fin) state_q <= ST_EXEC;
				ST_DIV: if (fin) state_q <= ST_EXEC;
				default: state_q <= ST_EXEC;
			endcase
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (fin) begin
				out_valid <= 1'b1;
				cr_q <= cr_n; ca_q <= ca_n; ov_q <= ov_n; so_q <= so_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_value <= res; dest_index <= dst; write_enable <= we;
			cr_out <= cr_n; carry_out <= ca_n; overflow_out <= ov_n;
			summary_overflow_out <= so_n; illegal <= ill;
		end
	end

	a_so_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(so_q) && $past(arst_n) |-> so_q) else $error("SO cleared");
	a_ill_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> !write_enable) else $error("illegal word writes");
	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> slot_free) else $error("result overwritten");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && div_busy |-> !fin) else $error("divide finished early");

endmodule

// ===== tb/tb_ppc_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppc_integer_execute_unit
// Drives directed and then random instruction words through the integer
// execute unit and checks every result word against a local model of the
// ALU, CR and XER state, with random register values, gaps and stalls on both channels.
// ----------------------------------------------------------------------------

typedef struct {
	logic [31:0] result_value;
	logic [4:0]  dest_index;
	logic        write_enable;
	logic [31:0] cr_out;
	logic        carry_out;
	logic        overflow_out;
	logic        summary_overflow_out;
	logic        illegal;
} exec_word_t;

class exec_scoreboard;
	logic [31:0] cr;
	logic ca, ov, so;
	exec_word_t pending[$];
	int errors;

	function new();
		cr = '0; ca = 0; ov = 0; so = 0; errors = 0;
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	function logic [3:0] cmp_code(logic lt, logic gt);
		return lt ? {3'b100, so} : gt ? {3'b010, so} : {3'b001, so};
	endfunction

	function void put_field(logic [2:0] fld, logic [3:0] code);
		cr[31 - fld*4 -: 4] = code;
	endfunction

	function void set_cr0(logic [31:0] v);
		put_field(0, cmp_code(v[31], !v[31] && v != 0));
	endfunction

	function logic [31:0] add3(logic [31:0] x, logic [31:0] y, logic cin,
			output logic co, output logic vo);
		logic [32:0] t;
		t = {1'b0, x} + {1'b0, y} + cin;
		co = t[32];
		vo = (t[31] ^ x[31]) & (t[31] ^ y[31]);
		return t[31:0];
	endfunction

	function logic [31:0] sra_op(logic [31:0] v, logic [5:0] sh, output logic co);
		logic [31:0] lost;
		if (sh == 0) begin
			co = 0;
			return v;
		end
		if (sh > 31) begin
			co = v[31];
			return {32{v[31]}};
		end
		lost = v & ((32'd1 << sh) - 1);
		co = v[31] && lost != 0;
		return $signed(v) >>> sh;
	endfunction

	// compute the result word for one accepted instruction and advance state
	function void note_input(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
			logic [31:0] s);
		exec_word_t w;
		logic [4:0] rd, ra, rbf, mb, me;
		logic rc, oe, c, v, bit_v, logic_rc, setca;
		logic [31:0] res, simm, uimm, m, r, hi;
		logic [63:0] p;
		logic [9:0] x10;
		logic [8:0] xo;
		logic [4:0] dst;
		logic we, ill;
		rd = ins[25:21]; ra = ins[20:16]; rbf = ins[15:11];
		rc = ins[0]; oe = ins[10]; x10 = ins[10:1]; xo = ins[9:1];
		uimm = {16'd0, ins[15:0]}; simm = {{16{ins[15]}}, ins[15:0]};
		res = 0; dst = 0; we = 0; ill = 0; c = 0; v = 0; logic_rc = 0; setca = 0;
		case (ins[31:26])
			7: begin res = a * simm; dst = rd; we = 1; end
			8: begin res = add3(~a, simm, 1, c, v); ca = c; dst = rd; we = 1; end
			10: put_field(rd[4:2], cmp_code(a < uimm, a > uimm));
			11: put_field(rd[4:2], cmp_code($signed(a) < $signed(simm),
				$signed(simm) < $signed(a)));
			12, 13: begin
				res = add3(a, simm, 0, c, v); ca = c; dst = rd; we = 1;
				if (ins[26]) set_cr0(res);
			end
			14: begin res = (ra != 0 ? a : 0) + simm; dst = rd; we = 1; end
			15: begin res = (ra != 0 ? a : 0) + (uimm << 16); dst = rd; we = 1; end
			19: begin
				bit_v = cr[31 - ra] ^ cr[31 - rbf];
				if (x10 == 193) cr[31 - rd] = bit_v;
				else if (x10 == 289) cr[31 - rd] = ~bit_v;
				else ill = 1;
			end
			20, 21: begin
				mb = ins[10:6]; me = ins[5:1];
				m = (mb <= me) ? ((32'hffffffff >> mb) & (32'hffffffff << (31 - me)))
					: ((32'hffffffff >> mb) | (32'hffffffff << (31 - me)));
				r = ({s, s} << rbf) >> 32;
				r = r & m;
				res = ins[26] ? r : (r | (a & ~m));
				dst = ra; we = 1; logic_rc = rc;
			end
			24: begin res = s | uimm; dst = ra; we = 1; end
			25: begin res = s | (uimm << 16); dst = ra; we = 1; end
			26: begin res = s ^ uimm; dst = ra; we = 1; end
			27: begin res = s ^ (uimm << 16); dst = ra; we = 1; end
			28: begin res = s & uimm; dst = ra; we = 1; logic_rc = 1; end
			29: begin res = s & (uimm << 16); dst = ra; we = 1; logic_rc = 1; end
			31: begin
				dst = ra; we = 1; logic_rc = rc;
				case (x10)
					0, 32: begin
						we = 0; dst = 0; logic_rc = 0;
						if (x10 == 0)
							put_field(rd[4:2], cmp_code($signed(a) < $signed(b),
								$signed(b) < $signed(a)));
						else
							put_field(rd[4:2], cmp_code(a < b, a > b));
					end
					19: begin res = cr; dst = rd; logic_rc = 0; end
					144: begin
						m = 0;
						for (int i = 0; i < 8; i++)
							if (ins[12 + i]) m |= 32'hf << (i * 4);
						cr = (s & m) | (cr & ~m);
						we = 0; dst = 0; logic_rc = 0;
					end
					24: res = b[5] ? 0 : s << b[4:0];
					536: res = b[5] ? 0 : s >> b[4:0];
					792: begin res = sra_op(s, b[5:0], c); ca = c; end
					824: begin res = sra_op(s, {1'b0, rbf}, c); ca = c; end
					28: res = s & b;
					60: res = s & ~b;
					124: res = ~(s | b);
					444: res = s | b;
					412: res = s | ~b;
					316: res = s ^ b;
					26: begin
						res = 32;
						for (int i = 31; i >= 0; i--)
							if (s[i] && res == 32) res = 31 - i;
					end
					default: begin
						dst = rd; logic_rc = 0;
						case (xo)
							266: res = add3(a, b, 0, c, v);
							10: begin res = add3(a, b, 0, c, v); setca = 1; end
							138: begin res = add3(a, b, ca, c, v); setca = 1; end
							40: res = add3(~a, b, 1, c, v);
							8: begin res = add3(~a, b, 1, c, v); setca = 1; end
							136: begin res = add3(~a, b, ca, c, v); setca = 1; end
							202: begin res = add3(a, 0, ca, c, v); setca = 1; end
							104: res = add3(~a, 0, 1, c, v);
							235: begin
								p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
								res = p[31:0];
								v = p[63:32] != {32{p[31]}};
							end
							459: begin
								if (b == 0) begin v = 1; we = 0; end
								else res = a / b;
							end
							11: begin
								p = {32'd0, a} * {32'd0, b};
								if (oe) ill = 1; else res = p[63:32];
							end
							75: begin
								p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
								if (oe) ill = 1; else res = p[63:32];
							end
							default: ill = 1;
						endcase
						if (!ill) begin
							if (setca) ca = c;
							if (oe) begin ov = v; so = so | v; end
							if (rc) begin
								if (we) set_cr0(res);
								else cr[28] = so;
							end
						end
					end
				endcase
			end
			default: ill = 1;
		endcase
		if (ill) begin res = 0; dst = 0; we = 0; logic_rc = 0; end
		if (!we) res = 0;
		if (logic_rc) set_cr0(res);
		w.result_value = res; w.dest_index = dst; w.write_enable = we;
		w.cr_out = cr; w.carry_out = ca; w.overflow_out = ov;
		w.summary_overflow_out = so; w.illegal = ill;
		pending.push_back(w);
	endfunction

	task check_result(exec_word_t got);
		exec_word_t e;
		if (pending.size() == 0) begin
			report("unexpected word", got.result_value, 0);
			return;
		end
		e = pending.pop_front();
		if (got.result_value !== e.result_value)
			report("result_value", got.result_value, e.result_value);
		if (got.dest_index !== e.dest_index) report("dest_index", got.dest_index, e.dest_index);
		if (got.write_enable !== e.write_enable)
			report("write_enable", got.write_enable, e.write_enable);
		if (got.cr_out !== e.cr_out) report("cr_out", got.cr_out, e.cr_out);
		if (got.carry_out !== e.carry_out) report("carry_out", got.carry_out, e.carry_out);
		if (got.overflow_out !== e.overflow_out)
			report("overflow_out", got.overflow_out, e.overflow_out);
		if (got.summary_overflow_out !== e.summary_overflow_out)
			report("summary_overflow_out", got.summary_overflow_out, e.summary_overflow_out);
		if (got.illegal !== e.illegal) report("illegal", got.illegal, e.illegal);
	endtask
endclass

module tb_ppc_integer_execute_unit;
	import ppcx_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [5:0] P_MULLI = 7, P_SUBFIC = 8, P_CMPLI = 10, P_CMPI = 11,
		P_ADDIC = 12, P_ADDICD = 13, P_ADDI = 14, P_ADDIS = 15, P_CR = 19,
		P_RLWIMI = 20, P_RLWINM = 21, P_ORI = 24, P_ORIS = 25, P_XORI = 26,
		P_XORIS = 27, P_ANDI = 28, P_ANDIS = 29, P_X = 31;
	localparam logic [9:0] X_CMP = 0, X_CMPL = 32, X_MFCR = 19, X_MTCRF = 144,
		X_SLW = 24, X_SRW = 536, X_SRAW = 792, X_SRAWI = 824, X_AND = 28,
		X_ANDC = 60, X_NOR = 124, X_OR = 444, X_ORC = 412, X_XOR = 316,
		X_CNTLZW = 26, X_CRXOR = 193, X_CREQV = 289;
	localparam logic [8:0] XO_ADD = 266, XO_ADDC = 10, XO_ADDE = 138, XO_SUBF = 40,
		XO_SUBFC = 8, XO_SUBFE = 136, XO_ADDZE = 202, XO_NEG = 104, XO_MULLW = 235,
		XO_DIVWU = 459, XO_MULHWU = 11, XO_MULHW = 75;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic in_ready, out_valid;
	logic [31:0] instruction = 0, reg_a_value = 0, reg_b_value = 0, reg_s_value = 0;
	logic [31:0] result_value, cr_out;
	logic [4:0] dest_index;
	logic write_enable, carry_out, overflow_out, summary_overflow_out, illegal;
	int cycles = 0;
	exec_scoreboard sb = new();

	ppc_integer_execute_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, check each accepted word
	initial begin
		exec_word_t w;
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			// sample mid-cycle so the word seen is the one taken at the next edge
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			w.result_value = result_value; w.dest_index = dest_index;
			w.write_enable = write_enable; w.cr_out = cr_out; w.carry_out = carry_out;
			w.overflow_out = overflow_out;
			w.summary_overflow_out = summary_overflow_out; w.illegal = illegal;
			@(posedge clk);
			sb.check_result(w);
		end
	end

	task automatic send_word(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
			logic [31:0] s, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		instruction <= ins; reg_a_value <= a; reg_b_value <= b; reg_s_value <= s;
		// ready is settled mid-cycle; the word goes in at the following edge
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		sb.note_input(ins, a, b, s);
	endtask

	function automatic logic [31:0] random_word();
		logic [31:0] ins;
		logic [5:0] prims[18] = '{P_MULLI, P_SUBFIC, P_CMPLI, P_CMPI, P_ADDIC,
			P_ADDICD, P_ADDI, P_ADDIS, P_CR, P_RLWIMI, P_RLWINM, P_ORI, P_ORIS,
			P_XORI, P_XORIS, P_ANDI, P_ANDIS, P_X};
		logic [9:0] xs[17] = '{X_CMP, X_CMPL, X_MFCR, X_MTCRF, X_SLW, X_SRW, X_SRAW,
			X_SRAWI, X_AND, X_ANDC, X_NOR, X_OR, X_ORC, X_XOR, X_CNTLZW, X_CRXOR, X_CREQV};
		logic [8:0] xos[12] = '{XO_ADD, XO_ADDC, XO_ADDE, XO_SUBF, XO_SUBFC, XO_SUBFE,
			XO_ADDZE, XO_NEG, XO_MULLW, XO_DIVWU, XO_MULHWU, XO_MULHW};
		int k;
		ins = $urandom;
		k = $urandom_range(0, 9);
		if (k == 0) return ins;
		if (k < 4) ins[31:26] = prims[$urandom_range(0, 17)];
		else if (k < 7) begin
			ins[10:1] = xs[$urandom_range(0, 16)];
			ins[31:26] = (ins[10:1] == X_CRXOR || ins[10:1] == X_CREQV) ? P_CR : P_X;
		end else begin
			ins[31:26] = P_X;
			ins[9:1] = xos[$urandom_range(0, 11)];
		end
		return ins;
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return $urandom_range(0, 70);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] ins, b;
		int gap;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, overflow, carry, divide by zero, shifts past 31
		send_word({P_ADDI, 5'd3, 5'd0, 16'h8000}, 32'hffffffff, 0, 0, 0);
		send_word({P_ADDIS, 5'd3, 5'd4, 16'hffff}, 32'h7fffffff, 0, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, 1'b1, XO_ADD, 1'b1}, 32'h7fffffff, 1, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, 1'b1, XO_SUBFC, 1'b1}, 32'h80000000, 1, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, 1'b1, XO_DIVWU, 1'b1}, 32'd7, 0, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, 1'b0, XO_DIVWU, 1'b1}, 32'hffffffff, 3, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, 1'b1, XO_MULLW, 1'b1}, 32'h80000000, 32'hffffffff, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, 1'b1, XO_MULHW, 1'b0}, 1, 1, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, 1'b0, XO_MULHWU, 1'b0}, 32'hffffffff,
			32'hffffffff, 0, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, X_SLW, 1'b1}, 0, 40, 32'hffffffff, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, X_SRAW, 1'b1}, 0, 33, 32'h80000000, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd31, X_SRAWI, 1'b0}, 0, 0, 32'h80000001, 0);
		send_word({P_X, 5'd1, 5'd2, 5'd3, X_CNTLZW, 1'b1}, 0, 0, 0, 0);
		send_word({P_X, 5'd31, 1'b0, 8'hff, 1'b0, X_MTCRF, 1'b0}, 0, 0, 32'ha5c3f00f, 0);
		send_word({P_CR, 5'd0, 5'd31, 5'd1, X_CREQV, 1'b0}, 0, 0, 0, 0);
		send_word({P_CR, 5'd31, 5'd0, 5'd2, X_CRXOR, 1'b0}, 0, 0, 0, 0);
		send_word({P_X, 5'd9, 5'd0, 5'd0, X_MFCR, 1'b0}, 0, 0, 0, 0);
		send_word({P_CMPI, 5'd28, 5'd1, 16'h8000}, 32'h80000000, 0, 0, 0);
		send_word({P_CMPLI, 5'd4, 5'd1, 16'hffff}, 32'hffff, 0, 0, 0);
		send_word({P_RLWIMI, 5'd1, 5'd2, 5'd31, 5'd30, 5'd1, 1'b1}, 32'h1234, 0,
			32'hdeadbeef, 0);
		send_word({P_RLWINM, 5'd1, 5'd2, 5'd0, 5'd0, 5'd31, 1'b1}, 0, 0, 32'h80000000, 0);
		send_word({P_ANDI, 5'd1, 5'd2, 16'h0}, 0, 0, 32'hffffffff, 0);
		send_word({6'd32, 26'h0}, 0, 0, 0, 0);
		in_valid <= 0;
		// hold until every expected word has come back
		while (sb.pending.size() != 0) @(posedge clk);
		for (int n = 0; n < 600; n++) begin
			ins = random_word();
			b = random_value();
			gap = (n % 150 < 40) ? 0 : $urandom_range(0, 3);
			send_word(ins, random_value(), b, random_value(), gap);
		end
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/ppcx_pkg.sv
src/ppcx_front.sv
src/ppcx_div.sv
src/ppcx_back.sv
src/ppc_integer_execute_unit.sv
tb/tb_ppc_integer_execute_unit.sv
